@@ rtl/cdbrs_pkg.sv @@
// ----------------------------------------------------------------------------
// CD block read sequencer package
// Shared widths, codes, item types and the small BCD helper.
// ----------------------------------------------------------------------------
package cdbrs_pkg;

   // Field widths.
   localparam int REQ_TYPE_W     = 2;
   localparam int SECTOR_W       = 19;
   localparam int COUNT_W        = 16;
   localparam int ATTEMPT_W      = 17;
   localparam int RETRY_W        = 4;
   localparam int ACTION_W       = 3;
   localparam int EXC_W          = 3;
   localparam int MIN_BCD_W      = 8;
   localparam int SEC_BCD_W      = 7;
   localparam int FRAME_BCD_W    = 7;

   // Configuration port.
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = ATTEMPT_W;

   // Register reset values.
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT_RESET = ATTEMPT_W'(99999);
   localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RESET   = RETRY_W'(10);

   // Address conversion constants.
   localparam int LBA_W          = SECTOR_W + 1;
   localparam int LEAD_IN        = 150;
   localparam int SECTORS_PER_MIN = 4500;
   localparam int SECTORS_PER_SEC = 75;
   // Reciprocals, rounded down, so each estimate is low by at most one.
   localparam int RECIP_MIN      = 59652;
   localparam int RECIP_MIN_SH   = 28;
   localparam int RECIP_MIN_W    = 16;
   localparam int RECIP_SEC      = 873;
   localparam int RECIP_SEC_SH   = 16;
   localparam int RECIP_SEC_W    = 10;
   localparam int MIN_W          = 7;
   localparam int REM_W          = 13;
   localparam int SEC_W          = 6;
   localparam int FRAME_W        = 8;

   // FIFO depth for results.
   localparam int RSP_DEPTH      = 4;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_START      = 2'd0,
      REQ_CMD_POLL   = 2'd1,
      REQ_EVENT_POLL = 2'd2
   } req_kind_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SEEK    = 3'd0,
      ACT_READ    = 3'd1,
      ACT_POLL    = 3'd2,
      ACT_OK      = 3'd3,
      ACT_FAIL    = 3'd4,
      ACT_IGNORED = 3'd5
   } action_type;

   typedef enum logic [EXC_W-1:0] {
      EXC_NONE         = 3'd0,
      EXC_SEEK_TIMEOUT = 3'd1,
      EXC_READ_FAIL    = 3'd2,
      EXC_RETRY        = 3'd3,
      EXC_END          = 3'd4
   } exc_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTEMPT_LIMIT = 2'd0,
      CSR_RETRY_LIMIT   = 2'd1
   } csr_index_type;

   // One input item as it travels down the conversion pipeline.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [SECTOR_W-1:0]   start_sector;
      logic [COUNT_W-1:0]    sector_count;
      logic                  cmd_accepted;
      logic                  event_done;
      logic                  event_error;
      logic                  event_end;
   } req_fields_type;

   // Item leaving the last conversion stage.
   typedef struct packed {
      req_fields_type        req;
      logic [MIN_BCD_W-1:0]  min_bcd;
      logic [REM_W-1:0]      rem;
      logic [SEC_W-1:0]      sec_est;
   } conv_item_type;

   // One result item.
   typedef struct packed {
      logic [ACTION_W-1:0]    action;
      logic [EXC_W-1:0]       exception_code;
      logic [MIN_BCD_W-1:0]   msf_minute_bcd;
      logic [SEC_BCD_W-1:0]   msf_second_bcd;
      logic [FRAME_BCD_W-1:0] msf_frame_bcd;
      logic [COUNT_W-1:0]     read_amount;
      logic                   last;
   } rsp_fields_type;

   // Results pushed by the sequencer core in one cycle.
   typedef struct packed {
      logic           valid;
      logic           two;
      rsp_fields_type first;
      rsp_fields_type second;
   } rsp_push_type;

   // Two BCD digits of a value below 128; the tens digit may exceed nine.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'(205);
      tens = prod[14:11];
      ones = v - 7'(7'(tens) * 7'(10));
      return {tens, ones[3:0]};
   endfunction

endpackage

@@ rtl/cdbrs_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one request or poll item.
// ----------------------------------------------------------------------------
interface cdbrs_req_if
   import cdbrs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SECTOR_W-1:0]   start_sector;
   logic [COUNT_W-1:0]    sector_count;
   logic                  cmd_accepted;
   logic                  event_done;
   logic                  event_error;
   logic                  event_end;

   modport source (
      output valid, req_type, start_sector, sector_count,
             cmd_accepted, event_done, event_error, event_end,
      input  ready
   );

   modport sink (
      input  valid, req_type, start_sector, sector_count,
             cmd_accepted, event_done, event_error, event_end,
      output ready
   );
endinterface

@@ rtl/cdbrs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface cdbrs_rsp_if
   import cdbrs_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [EXC_W-1:0]       exception_code;
   logic [MIN_BCD_W-1:0]   msf_minute_bcd;
   logic [SEC_BCD_W-1:0]   msf_second_bcd;
   logic [FRAME_BCD_W-1:0] msf_frame_bcd;
   logic [COUNT_W-1:0]     read_amount;
   logic                   last;

   modport source (
      output valid, action, exception_code, msf_minute_bcd, msf_second_bcd,
             msf_frame_bcd, read_amount, last,
      input  ready
   );

   modport sink (
      input  valid, action, exception_code, msf_minute_bcd, msf_second_bcd,
             msf_frame_bcd, read_amount, last,
      output ready
   );
endinterface

@@ rtl/cdbrs_msf_pipe.sv @@
// ----------------------------------------------------------------------------
// Address conversion pipeline
// Registers each input item and works the sector address into minute,
// remainder and second estimate over three further stages.
// ----------------------------------------------------------------------------
module cdbrs_msf_pipe
   import cdbrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   cdbrs_req_if.sink     req_chan,
   output logic          out_valid,
   output conv_item_type out_item,
   input  logic          out_ready
);

   // Stage valid bits.
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic d_valid_ff, d_valid_in;

   // Stage payloads.
   req_fields_type     a_req_ff;
   req_fields_type     b_req_ff;
   logic [LBA_W-1:0]   b_lba_ff;
   logic [MIN_W-1:0]   b_min_est_ff;
   req_fields_type     c_req_ff;
   logic [MIN_W-1:0]   c_min_ff;
   logic [REM_W-1:0]   c_rem_ff;
   conv_item_type      d_item_ff;

   logic a_free, b_free, c_free, d_free;

   // Combinational stage results.
   req_fields_type                    in_req;
   logic [LBA_W-1:0]                  lba;
   logic [LBA_W+RECIP_MIN_W-1:0]      min_prod;
   logic [LBA_W-1:0]                  rem_est;
   logic [MIN_W-1:0]                  min_fix;
   logic [REM_W-1:0]                  rem_fix;
   logic [REM_W+RECIP_SEC_W-1:0]      sec_prod;

   // A stage is free when it is empty or its item moves on this cycle.
   assign d_free = !d_valid_ff || out_ready;
   assign c_free = !c_valid_ff || d_free;
   assign b_free = !b_valid_ff || c_free;
   assign a_free = !a_valid_ff || b_free;

   assign req_chan.ready = a_free;

   assign in_req.req_type     = req_chan.req_type;
   assign in_req.start_sector = req_chan.start_sector;
   assign in_req.sector_count = req_chan.sector_count;
   assign in_req.cmd_accepted = req_chan.cmd_accepted;
   assign in_req.event_done   = req_chan.event_done;
   assign in_req.event_error  = req_chan.event_error;
   assign in_req.event_end    = req_chan.event_end;

   assign a_valid_in = a_free ? req_chan.valid : a_valid_ff;
   assign b_valid_in = b_free ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_free ? b_valid_ff : c_valid_ff;
   assign d_valid_in = d_free ? c_valid_ff : d_valid_ff;

   // Lead-in added and the minute estimated by reciprocal multiplication.
   always_comb begin
      lba      = LBA_W'(a_req_ff.start_sector) + LBA_W'(LEAD_IN);
      min_prod = (LBA_W+RECIP_MIN_W)'(lba) * (LBA_W+RECIP_MIN_W)'(RECIP_MIN);
   end

   // Remainder within the minute, with the estimate corrected by one.
   always_comb begin
      rem_est = b_lba_ff - LBA_W'(LBA_W'(b_min_est_ff) * LBA_W'(SECTORS_PER_MIN));
      if (rem_est >= LBA_W'(SECTORS_PER_MIN)) begin
         min_fix = b_min_est_ff + MIN_W'(1);
         rem_fix = REM_W'(rem_est - LBA_W'(SECTORS_PER_MIN));
      end else begin
         min_fix = b_min_est_ff;
         rem_fix = REM_W'(rem_est);
      end
   end

   // Second estimated from the remainder.
   assign sec_prod = (REM_W+RECIP_SEC_W)'(c_rem_ff) * (REM_W+RECIP_SEC_W)'(RECIP_SEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   // Payload registers load as their stage takes an item.
   always_ff @(posedge clock) begin
      if (a_free && req_chan.valid) begin
         a_req_ff <= in_req;
      end
      if (b_free && a_valid_ff) begin
         b_req_ff     <= a_req_ff;
         b_lba_ff     <= lba;
         b_min_est_ff <= min_prod[RECIP_MIN_SH+MIN_W-1:RECIP_MIN_SH];
      end
      if (c_free && b_valid_ff) begin
         c_req_ff <= b_req_ff;
         c_min_ff <= min_fix;
         c_rem_ff <= rem_fix;
      end
      if (d_free && c_valid_ff) begin
         d_item_ff.req     <= c_req_ff;
         d_item_ff.min_bcd <= to_bcd(c_min_ff);
         d_item_ff.rem     <= c_rem_ff;
         d_item_ff.sec_est <= sec_prod[RECIP_SEC_SH+SEC_W-1:RECIP_SEC_SH];
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;

endmodule

@@ rtl/cdbrs_core.sv @@
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the phase, counters, target address and registers, and turns each
// converted item into one or two result items.
// ----------------------------------------------------------------------------
module cdbrs_core
   import cdbrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   in_valid,
   input  conv_item_type          in_item,
   input  logic                   room,
   output rsp_push_type           push
);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_SEEK_CMD  = 5'b00010,
      PH_SEEK_WAIT = 5'b00100,
      PH_READ_CMD  = 5'b01000,
      PH_READ_WAIT = 5'b10000
   } phase_type;

   localparam int MSF_W = MIN_BCD_W + SEC_BCD_W + FRAME_BCD_W;

   phase_type              phase_ff, phase_in;
   logic [RETRY_W-1:0]     round_ff, round_in;
   logic [ATTEMPT_W-1:0]   attempts_ff, attempts_in;
   logic [MSF_W-1:0]       msf_ff, msf_in;
   logic [COUNT_W-1:0]     pending_ff, pending_in;
   logic [ATTEMPT_W-1:0]   attempt_limit_ff;
   logic [RETRY_W-1:0]     retry_limit_ff;

   logic                   take;
   logic [FRAME_W-1:0]     frame_est;
   logic [SEC_W-1:0]       sec_fix;
   logic [FRAME_W-1:0]     frame_fix;
   logic [MSF_W-1:0]       new_msf;
   logic [RETRY_W-1:0]     round_next;
   rsp_fields_type         r0, r1;
   logic                   two;

   assign take = in_valid && room;

   // Last step of the conversion: frame from the second estimate.
   always_comb begin
      frame_est = FRAME_W'(in_item.rem - REM_W'(REM_W'(in_item.sec_est) *
                                                 REM_W'(SECTORS_PER_SEC)));
      if (frame_est >= FRAME_W'(SECTORS_PER_SEC)) begin
         sec_fix   = in_item.sec_est + SEC_W'(1);
         frame_fix = frame_est - FRAME_W'(SECTORS_PER_SEC);
      end else begin
         sec_fix   = in_item.sec_est;
         frame_fix = frame_est;
      end
      new_msf = {in_item.min_bcd,
                 SEC_BCD_W'(to_bcd(7'(sec_fix))),
                 FRAME_BCD_W'(to_bcd(frame_fix[6:0]))};
   end

   assign round_next = round_ff + RETRY_W'(1);

   // Phase update and result selection.
   always_comb begin
      phase_in    = phase_ff;
      round_in    = round_ff;
      attempts_in = attempts_ff;
      msf_in      = msf_ff;
      pending_in  = pending_ff;
      two         = 1'b0;
      r0          = '0;
      r0.action   = ACT_IGNORED;
      r0.last     = 1'b1;
      r1          = '0;
      r1.last     = 1'b1;

      case (req_kind_type'(in_item.req.req_type))
         REQ_START: begin
            msf_in      = new_msf;
            pending_in  = in_item.req.sector_count;
            round_in    = '0;
            attempts_in = attempt_limit_ff;
            phase_in    = PH_SEEK_CMD;
            r0.action   = ACT_SEEK;
            {r0.msf_minute_bcd, r0.msf_second_bcd, r0.msf_frame_bcd} = new_msf;
         end
         REQ_CMD_POLL: begin
            if (phase_ff inside {PH_SEEK_CMD, PH_READ_CMD}) begin
               if (in_item.req.cmd_accepted) begin
                  phase_in  = (phase_ff == PH_SEEK_CMD) ? PH_SEEK_WAIT : PH_READ_WAIT;
                  r0.action = ACT_POLL;
               end else if (attempts_ff <= ATTEMPT_W'(1)) begin
                  attempts_in       = '0;
                  phase_in          = PH_IDLE;
                  r0.action         = ACT_FAIL;
                  r0.exception_code = (phase_ff == PH_SEEK_CMD) ? EXC_SEEK_TIMEOUT
                                                                : EXC_READ_FAIL;
               end else begin
                  attempts_in = attempts_ff - ATTEMPT_W'(1);
                  r0.action   = ACT_POLL;
               end
            end
         end
         REQ_EVENT_POLL: begin
            if (phase_ff == PH_SEEK_WAIT) begin
               if (in_item.req.event_done) begin
                  attempts_in    = attempt_limit_ff;
                  phase_in       = PH_READ_CMD;
                  r0.action      = ACT_READ;
                  r0.read_amount = pending_ff;
               end else if (in_item.req.event_error) begin
                  phase_in          = PH_IDLE;
                  r0.action         = ACT_FAIL;
                  r0.exception_code = EXC_READ_FAIL;
               end else begin
                  r0.action = ACT_POLL;
               end
            end else if (phase_ff == PH_READ_WAIT) begin
               if (in_item.req.event_done) begin
                  phase_in       = PH_IDLE;
                  r0.action      = ACT_OK;
                  r0.read_amount = pending_ff;
               end else if (in_item.req.event_error) begin
                  // Read error: report the retry, then reseek or give up.
                  two               = 1'b1;
                  r0.action         = ACT_POLL;
                  r0.exception_code = EXC_RETRY;
                  r0.last           = 1'b0;
                  round_in          = round_next;
                  if (round_next >= retry_limit_ff) begin
                     phase_in          = PH_IDLE;
                     r1.action         = ACT_FAIL;
                     r1.exception_code = EXC_READ_FAIL;
                  end else begin
                     attempts_in = attempt_limit_ff;
                     phase_in    = PH_SEEK_CMD;
                     r1.action   = ACT_SEEK;
                     {r1.msf_minute_bcd, r1.msf_second_bcd, r1.msf_frame_bcd} = msf_ff;
                  end
               end else if (in_item.req.event_end) begin
                  phase_in          = PH_IDLE;
                  r0.action         = ACT_FAIL;
                  r0.exception_code = EXC_END;
               end else begin
                  r0.action = ACT_POLL;
               end
            end
         end
         default: begin
            r0.action = ACT_IGNORED;
         end
      endcase
   end

   assign push.valid  = take;
   assign push.two    = two;
   assign push.first  = r0;
   assign push.second = r1;

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         round_ff    <= '0;
         attempts_ff <= '0;
         msf_ff      <= '0;
         pending_ff  <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         round_ff    <= round_in;
         attempts_ff <= attempts_in;
         msf_ff      <= msf_in;
         pending_ff  <= pending_in;
      end
   end

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         attempt_limit_ff <= ATTEMPT_LIMIT_RESET;
         retry_limit_ff   <= RETRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ATTEMPT_LIMIT: attempt_limit_ff <= csr_wdata;
            CSR_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata[RETRY_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

@@ rtl/cdbrs_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// Result FIFO
// Small queue that takes one or two result items a cycle and hands one item
// a cycle to the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module cdbrs_rsp_fifo
   import cdbrs_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         room,
   cdbrs_rsp_if.source  rsp_chan
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_fields_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic [CNT_W-1:0]   n_push;
   logic               pop;
   rsp_fields_type     head;

   // Space for two items is needed before the core may take an item.
   assign room    = count_ff <= CNT_W'(DEPTH - 2);
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign wr_next = PTR_W'((CNT_W'(wr_ptr_ff) + CNT_W'(1)) % CNT_W'(DEPTH));
   assign n_push  = push.valid ? (push.two ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0);

   always_comb begin
      wr_ptr_in = PTR_W'((CNT_W'(wr_ptr_ff) + n_push) % CNT_W'(DEPTH));
      rd_ptr_in = pop ? PTR_W'((CNT_W'(rd_ptr_ff) + CNT_W'(1)) % CNT_W'(DEPTH))
                      : rd_ptr_ff;
      count_in  = count_ff + n_push - (pop ? CNT_W'(1) : CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
         if (push.two) begin
            entry_ff[wr_next] <= push.second;
         end
      end
   end

   assign head = entry_ff[rd_ptr_ff];

   assign rsp_chan.valid          = count_ff != '0;
   assign rsp_chan.action         = head.action;
   assign rsp_chan.exception_code = head.exception_code;
   assign rsp_chan.msf_minute_bcd = head.msf_minute_bcd;
   assign rsp_chan.msf_second_bcd = head.msf_second_bcd;
   assign rsp_chan.msf_frame_bcd  = head.msf_frame_bcd;
   assign rsp_chan.read_amount    = head.read_amount;
   assign rsp_chan.last           = head.last;

endmodule

@@ rtl/cd_block_read_sequencer.sv @@
// ----------------------------------------------------------------------------
// CD block read sequencer
// Turns read requests and drive polls into seek, read and completion actions.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on req_chan (valid/ready). A start request carries a logical
// sector and a sector count; command and event polls report the drive's
// answers. Each item produces one result on rsp_chan, or two when a read
// error is reported while reading (the first has last low).
// csr_wr_en with csr_index writes attempt_limit (0) or retry_limit (1); write
// only while no item is in flight.
// A result enters the result queue once its item has passed the four-stage
// address conversion pipeline ahead of the sequencer core.
// Throughput: one item per cycle while the queue has room; the result
// channel moves one result a cycle while the receiver is ready.
// When the receiver stalls, results collect in a four-entry queue and the
// core stops taking converted items once fewer than two entries are free.
// Reset clears the pipeline and queue, returns the sequencer to idle and
// loads the register defaults (attempt_limit 99999, retry_limit 10).
// ----------------------------------------------------------------------------
module cd_block_read_sequencer
   import cdbrs_pkg::*;
#(
   parameter int RSP_FIFO_DEPTH = RSP_DEPTH
)(
   input  logic                   clock,
   input  logic                   reset,
   cdbrs_req_if.sink              req_chan,
   cdbrs_rsp_if.source            rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          conv_valid;
   conv_item_type conv_item;
   logic          room;
   rsp_push_type  push;

   // Address conversion stages.
   cdbrs_msf_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (conv_valid),
      .out_item  (conv_item),
      .out_ready (room)
   );

   // Phase and counters.
   cdbrs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (conv_valid),
      .in_item   (conv_item),
      .room      (room),
      .push      (push)
   );

   // Result queue.
   cdbrs_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule
